// File: hw/rtl/ipv4p_pkg.sv
`default_nettype none
package ipv4p_pkg;

  // Scan modes of the character loop
  typedef enum logic [2:0] {
    MODE_SEEK  = 3'd0,
    MODE_ZERO  = 3'd1,
    MODE_ZEROX = 3'd2,
    MODE_DEC   = 3'd3,
    MODE_OCT   = 3'd4,
    MODE_HEX   = 3'd5,
    MODE_DONE  = 3'd6
  } scan_mode_t;

  localparam int unsigned NUM_PARTS = 4;
  localparam int unsigned PART_W    = 32;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned CNT_W     = 3;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_7    = 8'h37;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_X_UP = 8'h58;

  localparam logic [POS_W-1:0] POS_MAX   = 4'd15;
  localparam logic [CNT_W-1:0] CNT_FULL  = 3'd4;
  localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;
  localparam logic [CNT_W-1:0] CNT_TWO   = 3'd2;
  localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;

  localparam int unsigned SHIFT_A = 24;
  localparam int unsigned SHIFT_B = 16;
  localparam int unsigned SHIFT_C = 8;

  // Character fed to the scan step
  typedef struct packed {
    logic       go;
    logic       last;
    logic [7:0] ch;
  } step_t;

  // Parts of one finished string
  typedef struct packed {
    logic [NUM_PARTS-1:0][PART_W-1:0] part_vals;
    logic [CNT_W-1:0]                 count;
  } result_t;

  // Hex digit decode: bit 4 flags a digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ipv4p_scan.sv
`default_nettype none
module ipv4p_scan #(
  parameter int unsigned MAX_START = 13
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ipv4p_pkg::step_t  step,
  output ipv4p_pkg::result_t     res
);

  localparam logic [ipv4p_pkg::POS_W-1:0] START_LIMIT = ipv4p_pkg::POS_W'(MAX_START);

  // Radix of the digit step
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  ipv4p_pkg::scan_mode_t                          mode_r, mode_nxt;
  logic [ipv4p_pkg::POS_W-1:0]                    pos_r, pos_nxt;
  logic [ipv4p_pkg::CNT_W-1:0]                    parts_r, parts_nxt;
  logic [ipv4p_pkg::ACC_W-1:0]                    acc_r, acc_nxt;
  logic                                           ovf_r, ovf_nxt;
  logic [ipv4p_pkg::NUM_PARTS-1:0][ipv4p_pkg::PART_W-1:0] pv_r, pv_nxt;

  always_comb begin
    logic [4:0]                  hd;
    logic                        is_oct;
    logic                        is_dec;
    logic                        do_acc;
    logic [1:0]                  base_sel;
    logic [3:0]                  dig;
    logic [ipv4p_pkg::ACC_W+3:0] wide;
    logic [ipv4p_pkg::ACC_W+3:0] prod;
    logic [ipv4p_pkg::ACC_W+3:0] sum;
    logic                        end_now;
    logic                        fin;
    logic [ipv4p_pkg::PART_W-1:0] fin_val;
    logic [7:0]                  end_ch;

    hd       = ipv4p_pkg::hex_digit(step.ch);
    is_oct   = step.ch inside {[ipv4p_pkg::CH_0:ipv4p_pkg::CH_7]};
    is_dec   = step.ch inside {[ipv4p_pkg::CH_0:ipv4p_pkg::CH_9]};
    do_acc   = 1'b0;
    base_sel = BASE_OCT;
    dig      = hd[3:0];
    end_now  = 1'b0;
    end_ch   = step.ch;

    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    parts_nxt = parts_r;
    pv_nxt    = pv_r;
    pos_nxt   = (pos_r < ipv4p_pkg::POS_MAX) ? pos_r + 1'b1 : pos_r;

    case (mode_r)
      ipv4p_pkg::MODE_SEEK: begin
        if (pos_r >= START_LIMIT || step.ch == ipv4p_pkg::CH_NUL) begin
          mode_nxt = ipv4p_pkg::MODE_DONE;
        end else if (step.ch == ipv4p_pkg::CH_0) begin
          acc_nxt  = '0;
          ovf_nxt  = 1'b0;
          mode_nxt = ipv4p_pkg::MODE_ZERO;
        end else if (step.ch inside {[ipv4p_pkg::CH_1:ipv4p_pkg::CH_9]}) begin
          acc_nxt  = ipv4p_pkg::ACC_W'(step.ch[3:0]);
          ovf_nxt  = 1'b0;
          mode_nxt = ipv4p_pkg::MODE_DEC;
        end
      end
      ipv4p_pkg::MODE_ZERO, ipv4p_pkg::MODE_OCT: begin
        if (mode_r == ipv4p_pkg::MODE_ZERO &&
            (step.ch == ipv4p_pkg::CH_X_LO || step.ch == ipv4p_pkg::CH_X_UP)) begin
          mode_nxt = ipv4p_pkg::MODE_ZEROX;
        end else if (is_oct) begin
          do_acc   = 1'b1;
          base_sel = BASE_OCT;
          mode_nxt = ipv4p_pkg::MODE_OCT;
        end else begin
          end_now = 1'b1;
        end
      end
      ipv4p_pkg::MODE_ZEROX: begin
        if (hd[4]) begin
          acc_nxt  = ipv4p_pkg::ACC_W'(hd[3:0]);
          mode_nxt = ipv4p_pkg::MODE_HEX;
        end else begin
          end_now = 1'b1;
          end_ch  = ipv4p_pkg::CH_X_LO;
        end
      end
      ipv4p_pkg::MODE_DEC: begin
        if (is_dec) begin
          do_acc   = 1'b1;
          base_sel = BASE_DEC;
        end else begin
          end_now = 1'b1;
        end
      end
      ipv4p_pkg::MODE_HEX: begin
        if (hd[4]) begin
          do_acc   = 1'b1;
          base_sel = BASE_HEX;
        end else begin
          end_now = 1'b1;
        end
      end
      default: begin
        mode_nxt = ipv4p_pkg::MODE_DONE;
      end
    endcase

    // Multiply-accumulate with saturation past 64 bits
    wide = {4'd0, acc_r};
    case (base_sel)
      BASE_DEC: prod = (wide << 3) + (wide << 1);
      BASE_HEX: prod = wide << 4;
      default:  prod = wide << 3;
    endcase
    sum = prod + {{ipv4p_pkg::ACC_W{1'b0}}, dig};
    if (do_acc) begin
      if (ovf_r || sum[ipv4p_pkg::ACC_W+3:ipv4p_pkg::ACC_W] != 4'd0) begin
        ovf_nxt = 1'b1;
        acc_nxt = '1;
      end else begin
        acc_nxt = sum[ipv4p_pkg::ACC_W-1:0];
      end
    end

    // Close the number: on an ending character, or at string end mid-number
    fin = end_now ||
          (step.last && mode_nxt != ipv4p_pkg::MODE_SEEK &&
           mode_nxt != ipv4p_pkg::MODE_DONE);
    fin_val = ovf_nxt ? '1 : acc_nxt[ipv4p_pkg::PART_W-1:0];
    if (fin) begin
      if (parts_r < ipv4p_pkg::CNT_FULL) begin
        pv_nxt[parts_r[1:0]] = fin_val;
        parts_nxt            = parts_r + 1'b1;
      end
      acc_nxt = '0;
      ovf_nxt = 1'b0;
      if (end_now) begin
        mode_nxt = (end_ch == ipv4p_pkg::CH_DOT && parts_nxt < ipv4p_pkg::CNT_FULL) ?
                   ipv4p_pkg::MODE_SEEK : ipv4p_pkg::MODE_DONE;
      end else begin
        mode_nxt = ipv4p_pkg::MODE_DONE;
      end
    end

    res.part_vals = pv_nxt;
    res.count     = parts_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ipv4p_pkg::MODE_SEEK;
      pos_r   <= '0;
      parts_r <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      pv_r    <= '0;
    end else if (step.go) begin
      if (step.last) begin
        mode_r  <= ipv4p_pkg::MODE_SEEK;
        pos_r   <= '0;
        parts_r <= '0;
        acc_r   <= '0;
        ovf_r   <= 1'b0;
        pv_r    <= '0;
      end else begin
        mode_r  <= mode_nxt;
        pos_r   <= pos_nxt;
        parts_r <= parts_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
        pv_r    <= pv_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ipv4p_assemble.sv
`default_nettype none
module ipv4p_assemble (
  input  wire ipv4p_pkg::result_t  res,
  output logic [31:0]              address,
  output logic                     valid_res,
  output logic [2:0]               part_count
);

  logic [31:0] p0, p1, p2, p3;

  assign p0 = res.part_vals[0];
  assign p1 = res.part_vals[1];
  assign p2 = res.part_vals[2];
  assign p3 = res.part_vals[3];

  // Short forms fold the trailing part into the low bits, wrapping mod 2^32
  always_comb begin
    case (res.count)
      ipv4p_pkg::CNT_FULL: begin
        address = (p0 << ipv4p_pkg::SHIFT_A) + (p1 << ipv4p_pkg::SHIFT_B) +
                  (p2 << ipv4p_pkg::SHIFT_C) + p3;
      end
      ipv4p_pkg::CNT_THREE: begin
        address = (p0 << ipv4p_pkg::SHIFT_A) + (p1 << ipv4p_pkg::SHIFT_B) + p2;
      end
      ipv4p_pkg::CNT_TWO:   address = (p0 << ipv4p_pkg::SHIFT_A) + p1;
      ipv4p_pkg::CNT_ONE:   address = p0;
      default:              address = '0;
    endcase
    valid_res  = (res.count inside {[ipv4p_pkg::CNT_ONE:ipv4p_pkg::CNT_FULL]});
    part_count = valid_res ? res.count : '0;
  end

endmodule
`default_nettype wire

// File: hw/rtl/ipv4_text_address_parser_unit.sv
`default_nettype none
// Dotted-text IPv4 address parser. Feed the string one character per item
// (in_ch) and flag the final character with in_last; one result item follows
// each string with the 32-bit host-order address, a flag that at least one
// numeric part was found, and the part count. Each part picks its base from
// its prefix (0x/0X hex, leading 0 octal, otherwise decimal), a part that
// passes 2^64-1 reads as all ones, and one, two, three or four parts form an
// address in the a, a.b, a.b.c or a.b.c.d style. Characters before a number
// are skipped, but a number must begin below character position MAX_START.
// Rate: one item per clock, sustained unless a last character waits for a
// busy result slot. A character is captured in the input register and then
// scanned; a string's last character loads the result register, which
// drives out_valid, and holds in the input register while an earlier result
// is untaken. The scan state loop (64-bit shift-add accumulate by the base
// and part store) sets that pace.
// While a result waits on out_ready, characters of the next string keep
// flowing; only a second last character waits for the result slot.
module ipv4_text_address_parser_unit #(
  parameter int unsigned MAX_START = 13
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_address,
  output logic             out_valid_res,
  output logic [2:0]       out_part_count
);

  // Input register
  logic       in_vld_r;
  logic [7:0] in_ch_r;
  logic       in_last_r;

  // Result register
  logic                 out_vld_r;
  ipv4p_pkg::result_t   out_res_r;

  ipv4p_pkg::step_t     step;
  ipv4p_pkg::result_t   scan_res;
  logic                 out_free;
  logic                 step_go;

  // Advance the held character unless it closes a string and the result
  // slot is still occupied.
  assign out_free = !out_vld_r || out_ready;
  assign step_go  = in_vld_r && (!in_last_r || out_free);
  assign in_ready = !in_vld_r || step_go;

  assign step.go   = step_go;
  assign step.last = in_last_r;
  assign step.ch   = in_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  // Payload holds while the register waits
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_ch_r   <= in_ch;
      in_last_r <= in_last;
    end
  end

  ipv4p_scan #(
    .MAX_START (MAX_START)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (scan_res)
  );

  // Load a result on the string's last character, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_go && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && in_last_r) begin
      out_res_r <= scan_res;
    end
  end

  ipv4p_assemble u_assemble (
    .res        (out_res_r),
    .address    (out_address),
    .valid_res  (out_valid_res),
    .part_count (out_part_count)
  );

  assign out_valid = out_vld_r;

endmodule
`default_nettype wire
